// ===== rtl/core/optical_flow_position_integrator_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the position integrator
// Short forms for clocked implication checks under the active-low reset.
// ----------------------------------------------------------------------------
`ifndef OPTICAL_FLOW_POSITION_INTEGRATOR_ASSERT_SVH
`define OPTICAL_FLOW_POSITION_INTEGRATOR_ASSERT_SVH

// same-cycle implication
`define OFPI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ofpi check failed");

// next-cycle implication
`define OFPI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ofpi check failed");

`endif

// ===== rtl/core/ofpi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofpi_pkg
// Shared constants, codes and the arctangent table of the position integrator.
// ----------------------------------------------------------------------------
package ofpi_pkg;

  localparam int ANGLE_BITS_DEF = 16;

  localparam logic [1:0] ACT_PLAIN = 2'd0;
  localparam logic [1:0] ACT_GYRO  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] REG_DIST_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 2'd1;

  localparam logic [23:0] DIST_SCALE_RST = 24'd220471;
  localparam logic [9:0]  PERIOD_RST     = 10'd5;

  localparam int ROT_DIVISOR = 1000;
  localparam int ROT_ROUND   = 500;

  localparam int          GAIN_W      = 21;
  localparam logic [20:0] CORDIC_GAIN = 21'd1273506;

  localparam int MOVE_W      = 44;
  localparam int ACC_W       = 48;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 96;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [31:0] ofpi_atan(input logic [4:0] idx);
    logic [31:0] r;
    unique case (idx)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051D;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2F9;
      5'd15: r = 32'h0000517C;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A2F;
      5'd19: r = 32'h00000517;
      5'd20: r = 32'h0000028B;
      5'd21: r = 32'h00000145;
      5'd22: r = 32'h000000A2;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000028;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000002;
      5'd29: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/ofpi_serial_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofpi_serial_mul
// Shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module ofpi_serial_mul #(
  parameter int   WA      = 8,
  parameter int   WB      = 8,
  parameter logic BSIGNED = 1'b0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [WA-1:0] a_i,
  input  logic [WB-1:0]        b_i,
  output logic                 done_o,
  output logic signed [WA+WB-1:0] prod_o
);
  localparam int CW = $clog2(WB);

  logic [CW-1:0]        cnt_q;
  logic                 busy_q, done_q, last;
  logic signed [WA-1:0] a_q;
  logic signed [WA:0]   hi_q, a_ext, addend, sum;
  logic [WB-1:0]        lo_q;
  logic [WA+WB:0]       full;

  assign last  = (cnt_q == CW'(WB - 1));
  assign a_ext = {a_q[WA-1], a_q};

  // sign bit of a signed multiplier weighs negative
  always_comb begin
    if (lo_q[0]) begin
      addend = (BSIGNED && last) ? -a_ext : a_ext;
    end else begin
      addend = '0;
    end
    sum = hi_q + addend;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= a_i;
      hi_q <= '0;
      lo_q <= b_i;
    end else if (busy_q) begin
      hi_q <= {sum[WA], sum[WA:1]};
      lo_q <= {sum[0], lo_q[WB-1:1]};
    end
  end

  assign full   = {hi_q, lo_q};
  assign prod_o = full[WA+WB-1:0];
  assign done_o = done_q;

endmodule

// ===== rtl/core/ofpi_serial_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofpi_serial_div
// Restoring division by the rotation divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ofpi_serial_div #(
  parameter int WN = 46
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [WN-1:0] dividend_i,
  output logic          done_o,
  output logic [WN-1:0] quot_o
);
  import ofpi_pkg::*;

  localparam int CW = $clog2(WN);
  localparam int RW = $clog2(ROT_DIVISOR);

  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q, last, ge;
  logic [RW-1:0] rem_q;
  logic [WN-1:0] q_q;
  logic [RW:0]   trial, diff;

  assign last  = (cnt_q == CW'(WN - 1));
  assign trial = {rem_q, q_q[WN-1]};
  assign ge    = (trial >= (RW+1)'(ROT_DIVISOR));
  assign diff  = trial - (RW+1)'(ROT_DIVISOR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // dividend shifts out at the top while quotient bits shift in below
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      q_q   <= dividend_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[RW-1:0] : trial[RW-1:0];
      q_q   <= {q_q[WN-2:0], ge};
    end
  end

  assign quot_o = q_q;
  assign done_o = done_q;

endmodule

// ===== rtl/core/ofpi_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofpi_cordic
// Iterative CORDIC rotation by heading, one step per cycle, then serial gain.
// ----------------------------------------------------------------------------
module ofpi_cordic #(
  parameter int ANGLE_BITS = 16,
  parameter int W          = 44
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [W-1:0] x_i,
  input  logic signed [W-1:0] y_i,
  input  logic [15:0]         heading_i,
  output logic                done_o,
  output logic signed [W-1:0] x_o,
  output logic signed [W-1:0] y_o
);
  import ofpi_pkg::*;

  localparam int CNTW = $clog2(ANGLE_BITS);
  localparam int PW   = W + GAIN_W;

  logic [CNTW-1:0]      cnt_q;
  logic                 run_q, gstart_q, last, flip;
  logic signed [W-1:0]  x_q, y_q, xs, ys;
  logic signed [32:0]   z_q, at;
  logic [15:0]          hd;
  logic signed [PW-1:0] gx, gy, rx, ry;
  logic                 gx_done;

  assign last = (cnt_q == CNTW'(ANGLE_BITS - 1));
  // second and third quadrant: negate vector, turn angle by half a turn
  assign flip = heading_i[15] ^ heading_i[14];
  assign hd   = flip ? (heading_i ^ 16'h8000) : heading_i;
  assign xs   = x_q >>> cnt_q;
  assign ys   = y_q >>> cnt_q;
  assign at   = {1'b0, ofpi_atan(5'(cnt_q))};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q    <= 1'b0;
      gstart_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      gstart_q <= run_q && last;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= flip ? -x_i : x_i;
      y_q <= flip ? -y_i : y_i;
      z_q <= {hd[15], hd, 16'h0000};
    end else if (run_q) begin
      if (!z_q[32]) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + at;
      end
    end
  end

  ofpi_serial_mul #(.WA(W), .WB(GAIN_W), .BSIGNED(1'b0)) u_gain_x (
    .clk_i, .rst_ni, .start_i(gstart_q), .a_i(x_q), .b_i(CORDIC_GAIN),
    .done_o(gx_done), .prod_o(gx)
  );

  ofpi_serial_mul #(.WA(W), .WB(GAIN_W), .BSIGNED(1'b0)) u_gain_y (
    .clk_i, .rst_ni, .start_i(gstart_q), .a_i(y_q), .b_i(CORDIC_GAIN),
    .done_o(), .prod_o(gy)
  );

  // round half up at the gain shift
  assign rx     = gx + (PW'(1) <<< (GAIN_W - 1));
  assign ry     = gy + (PW'(1) <<< (GAIN_W - 1));
  assign x_o    = rx[PW-1:GAIN_W];
  assign y_o    = ry[PW-1:GAIN_W];
  assign done_o = gx_done;

endmodule

// ===== rtl/core/optical_flow_position_integrator.sv =====
`timescale 1ns / 1ps
// Optical-flow position integrator: each word on the input stream is one flow sample and
// gives one word on the output stream holding the updated, saturating x/y position
// (mm, 16 fraction bits). Arithmetic is bit-serial: clear and the unused action go
// straight to the accumulate step, plain integration runs a 16-bit then a 10-bit
// shift-add multiply pass, and gyro mode adds the 46-bit serial divide, one CORDIC step
// per cycle and the 21-bit serial gain multiply. One item is worked on at a time; a
// finished position may wait in the output register while the next word is taken.
// Register writes go on a separate port that is always ready: index 0 distance scale,
// 1 loop period in ms.
// ----------------------------------------------------------------------------
// optical_flow_position_integrator
// Dead-reckoning position accumulator fed by optical-flow samples.
// ----------------------------------------------------------------------------
module optical_flow_position_integrator #(
  parameter int ANGLE_BITS = ofpi_pkg::ANGLE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ofpi_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ofpi_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // flow_dx, flow_dy, height_mm, rate_x, rate_y, heading
  input  logic [ofpi_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // action
  input  logic [1:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // pos_x, pos_y
  output logic [ofpi_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
  import ofpi_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL1 = 3'd1;
  localparam logic [2:0] ST_MUL2 = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_ROT  = 3'd4;
  localparam logic [2:0] ST_ACC  = 3'd5;

  logic [2:0]  state_q, state_d;
  logic [23:0] dist_scale_q;
  logic [9:0]  period_q;

  logic [1:0]         act_q;
  logic signed [7:0]  dx_q, dy_q;
  logic [15:0]        h_q, hd_q;
  logic signed [15:0] rx_q, ry_q;

  logic start1_q, start2_q, start_div_q, start_rot_q;
  logic in_acc, out_free;

  logic signed [MOVE_W-1:0] movx_q, movy_q;
  logic signed [ACC_W-1:0]  acc_x_q, acc_y_q;
  logic                     out_valid_q;
  logic [OUT_TDATA_W-1:0]   out_data_q;

  logic signed [40:0] sh_prod;
  logic signed [31:0] hy_prod, hx_prod;
  logic signed [48:0] fx_prod, fy_prod, fx_rnd, fy_rnd;
  logic signed [41:0] py_prod, px_prod;
  logic               sh_done, px_done, divx_done, rot_done;
  logic [41:0]        magy, magx;
  logic [45:0]        divy_in, divx_in, qy, qx;
  logic signed [MOVE_W-1:0] fmx, fmy, roty, rotx, cx, cy;
  logic signed [ACC_W:0]    sumx, sumy;
  logic signed [ACC_W-1:0]  newx, newy;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign out_free      = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_scale_q <= DIST_SCALE_RST;
      period_q     <= PERIOD_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_DIST_SCALE: dist_scale_q <= cfg_data_i;
        REG_PERIOD:     period_q     <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // --- serial multiply passes ---
  ofpi_serial_mul #(.WA(25), .WB(16), .BSIGNED(1'b0)) u_mul_sh (
    .clk_i, .rst_ni, .start_i(start1_q), .a_i({1'b0, dist_scale_q}), .b_i(h_q),
    .done_o(sh_done), .prod_o(sh_prod)
  );
  ofpi_serial_mul #(.WA(16), .WB(16), .BSIGNED(1'b0)) u_mul_hy (
    .clk_i, .rst_ni, .start_i(start1_q), .a_i(ry_q), .b_i(h_q),
    .done_o(), .prod_o(hy_prod)
  );
  ofpi_serial_mul #(.WA(16), .WB(16), .BSIGNED(1'b0)) u_mul_hx (
    .clk_i, .rst_ni, .start_i(start1_q), .a_i(rx_q), .b_i(h_q),
    .done_o(), .prod_o(hx_prod)
  );
  ofpi_serial_mul #(.WA(41), .WB(8), .BSIGNED(1'b1)) u_mul_fx (
    .clk_i, .rst_ni, .start_i(start2_q), .a_i(sh_prod), .b_i(dx_q),
    .done_o(), .prod_o(fx_prod)
  );
  ofpi_serial_mul #(.WA(41), .WB(8), .BSIGNED(1'b1)) u_mul_fy (
    .clk_i, .rst_ni, .start_i(start2_q), .a_i(sh_prod), .b_i(dy_q),
    .done_o(), .prod_o(fy_prod)
  );
  ofpi_serial_mul #(.WA(32), .WB(10), .BSIGNED(1'b0)) u_mul_py (
    .clk_i, .rst_ni, .start_i(start2_q), .a_i(hy_prod), .b_i(period_q),
    .done_o(), .prod_o(py_prod)
  );
  ofpi_serial_mul #(.WA(32), .WB(10), .BSIGNED(1'b0)) u_mul_px (
    .clk_i, .rst_ni, .start_i(start2_q), .a_i(hx_prod), .b_i(period_q),
    .done_o(px_done), .prod_o(px_prod)
  );

  // flow move, rounded half up at the 8-bit shift
  assign fx_rnd = fx_prod + 49'sd128;
  assign fy_rnd = fy_prod + 49'sd128;
  assign fmx    = MOVE_W'($signed(fx_rnd[48:8]));
  assign fmy    = MOVE_W'($signed(fy_rnd[48:8]));

  // rotation term: magnitude * 16 + half divisor, rounds half away from zero
  assign magy    = py_prod[41] ? 42'(-py_prod) : 42'(py_prod);
  assign magx    = px_prod[41] ? 42'(-px_prod) : 42'(px_prod);
  assign divy_in = {magy, 4'b0000} + 46'(ROT_ROUND);
  assign divx_in = {magx, 4'b0000} + 46'(ROT_ROUND);

  ofpi_serial_div #(.WN(46)) u_div_y (
    .clk_i, .rst_ni, .start_i(start_div_q), .dividend_i(divy_in),
    .done_o(), .quot_o(qy)
  );
  ofpi_serial_div #(.WN(46)) u_div_x (
    .clk_i, .rst_ni, .start_i(start_div_q), .dividend_i(divx_in),
    .done_o(divx_done), .quot_o(qx)
  );

  assign roty = py_prod[41] ? -$signed(qy[MOVE_W-1:0]) : $signed(qy[MOVE_W-1:0]);
  assign rotx = px_prod[41] ? -$signed(qx[MOVE_W-1:0]) : $signed(qx[MOVE_W-1:0]);

  ofpi_cordic #(.ANGLE_BITS(ANGLE_BITS), .W(MOVE_W)) u_cordic (
    .clk_i, .rst_ni, .start_i(start_rot_q), .x_i(movx_q), .y_i(movy_q),
    .heading_i(hd_q), .done_o(rot_done), .x_o(cx), .y_o(cy)
  );

  // --- saturating accumulate ---
  assign sumx = {acc_x_q[ACC_W-1], acc_x_q} + (ACC_W+1)'(movx_q);
  assign sumy = {acc_y_q[ACC_W-1], acc_y_q} + (ACC_W+1)'(movy_q);

  always_comb begin
    if (act_q == ACT_CLEAR) begin
      newx = '0;
      newy = '0;
    end else begin
      if (sumx[ACC_W] != sumx[ACC_W-1]) begin
        newx = sumx[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
        newx = sumx[ACC_W-1:0];
      end
      if (sumy[ACC_W] != sumy[ACC_W-1]) begin
        newy = sumy[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
        newy = sumy[ACC_W-1:0];
      end
    end
  end

  // --- sequencer ---
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser == ACT_PLAIN || s_axis_tuser == ACT_GYRO) begin
            state_d = ST_MUL1;
          end else begin
            state_d = ST_ACC;
          end
        end
      end
      ST_MUL1: if (sh_done) state_d = ST_MUL2;
      ST_MUL2: begin
        if (px_done) state_d = (act_q == ACT_GYRO) ? ST_DIV : ST_ACC;
      end
      ST_DIV:  if (divx_done) state_d = ST_ROT;
      ST_ROT:  if (rot_done) state_d = ST_ACC;
      ST_ACC:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      start1_q    <= 1'b0;
      start2_q    <= 1'b0;
      start_div_q <= 1'b0;
      start_rot_q <= 1'b0;
      out_valid_q <= 1'b0;
      acc_x_q     <= '0;
      acc_y_q     <= '0;
    end else begin
      state_q     <= state_d;
      start1_q    <= in_acc && (s_axis_tuser == ACT_PLAIN || s_axis_tuser == ACT_GYRO);
      start2_q    <= (state_q == ST_MUL1) && sh_done;
      start_div_q <= (state_q == ST_MUL2) && px_done && (act_q == ACT_GYRO);
      start_rot_q <= (state_q == ST_DIV) && divx_done;
      if (state_q == ST_ACC && out_free) begin
        acc_x_q     <= newx;
        acc_y_q     <= newy;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q <= s_axis_tuser;
      dx_q  <= s_axis_tdata[7:0];
      dy_q  <= s_axis_tdata[15:8];
      h_q   <= s_axis_tdata[31:16];
      rx_q  <= s_axis_tdata[47:32];
      ry_q  <= s_axis_tdata[63:48];
      hd_q  <= s_axis_tdata[79:64];
      movx_q <= '0;
      movy_q <= '0;
    end else if (state_q == ST_MUL2 && px_done) begin
      movx_q <= fmx;
      movy_q <= fmy;
    end else if (state_q == ST_DIV && divx_done) begin
      movx_q <= fmx - roty;
      movy_q <= fmy + rotx;
    end else if (state_q == ST_ROT && rot_done) begin
      movx_q <= cx;
      movy_q <= cy;
    end
    if (state_q == ST_ACC && out_free) begin
      out_data_q <= {newy, newx};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `include "optical_flow_position_integrator_assert.svh"

  `OFPI_ASSERT_NXT(a_accept_leaves_idle, in_acc, state_q != ST_IDLE)
  `OFPI_ASSERT_NXT(a_acc_holds_on_stall,
                   state_q == ST_ACC && out_valid_q && !m_axis_tready,
                   $stable(acc_x_q) && $stable(acc_y_q))
  `OFPI_ASSERT_IMP(a_result_from_acc, $rose(out_valid_q), $past(state_q) == ST_ACC)

endmodule

// ===== tb/tb_optical_flow_position_integrator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Position integrator testbench
// Drives flow samples at random pacing, and register writes. A scoreboard
// predicts each updated position and checks every output word in order.
// ----------------------------------------------------------------------------
module tb_optical_flow_position_integrator;
  import ofpi_pkg::*;

  localparam int NUM_RANDOM = 1250;
  localparam longint CYCLE_LIMIT = 2000000;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [15:0] heading;
    logic [15:0] rate_y;
    logic [15:0] rate_x;
    logic [15:0] height_mm;
    logic [7:0]  flow_dy;
    logic [7:0]  flow_dx;
  } sample_t;

  class position_scoreboard;
    logic [23:0] dist_scale;
    logic [9:0]  period;
    longint acc_x, acc_y;
    logic [95:0] pending_pos[$];
    int errors;

    function new();
      dist_scale = DIST_SCALE_RST;
      period = PERIOD_RST;
      acc_x = 0;
      acc_y = 0;
      errors = 0;
    endfunction

    function longint fshift(longint v, int s);
      return v >>> s;
    endfunction

    function longint flow_move(longint d, longint h);
      return fshift(d * longint'(dist_scale) * h + 128, 8);
    endfunction

    function longint rot_move(longint r, longint h);
      longint num, mag;
      num = r * h * longint'(period) * 16;
      mag = (num < 0) ? -num : num;
      mag = (mag + ROT_ROUND) / ROT_DIVISOR;
      return (num < 0) ? -mag : mag;
    endfunction

    function longint sat(longint v);
      longint hi;
      hi = 64'sh7FFF_FFFF_FFFF;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    function void rotate(inout longint x, inout longint y, input logic [31:0] ang);
      longint z, nx;
      logic [31:0] t;
      t = ang + 32'h4000_0000;
      if (t[31]) begin
        x = -x;
        y = -y;
        ang = ang + 32'h8000_0000;
      end
      z = longint'(signed'(ang));
      for (int i = 0; i < ANGLE_BITS_DEF; i++) begin
        if (z >= 0) begin
          nx = x - fshift(y, i);
          y = y + fshift(x, i);
          z -= longint'(ofpi_atan(i[4:0]));
        end else begin
          nx = x + fshift(y, i);
          y = y - fshift(x, i);
          z += longint'(ofpi_atan(i[4:0]));
        end
        x = nx;
      end
      x = fshift(x * longint'(CORDIC_GAIN) + (64'sd1 <<< 20), 21);
      y = fshift(y * longint'(CORDIC_GAIN) + (64'sd1 <<< 20), 21);
    endfunction

    function void note_sample(logic [1:0] act, sample_t s);
      longint dx, dy, h, mx, my;
      logic [47:0] px, py;
      dx = longint'(signed'(s.flow_dx));
      dy = longint'(signed'(s.flow_dy));
      h = longint'(s.height_mm);
      case (act)
        ACT_PLAIN: begin
          acc_x = sat(acc_x + flow_move(dx, h));
          acc_y = sat(acc_y + flow_move(dy, h));
        end
        ACT_GYRO: begin
          mx = flow_move(dx, h) - rot_move(longint'(signed'(s.rate_y)), h);
          my = flow_move(dy, h) + rot_move(longint'(signed'(s.rate_x)), h);
          rotate(mx, my, {s.heading, 16'h0});
          acc_x = sat(acc_x + mx);
          acc_y = sat(acc_y + my);
        end
        ACT_CLEAR: begin
          acc_x = 0;
          acc_y = 0;
        end
        default: ;
      endcase
      px = acc_x[47:0];
      py = acc_y[47:0];
      pending_pos.push_back({py, px});
    endfunction

    task report(string what, logic [47:0] got, logic [47:0] want);
      errors++;
      $display("mismatch %s: got %h want %h", what, got, want);
    endtask

    task check_position(logic [95:0] word);
      logic [95:0] w;
      if (pending_pos.size() == 0) begin
        report("unexpected word", word[47:0], 48'h0);
        return;
      end
      w = pending_pos.pop_front();
      if (word[47:0] !== w[47:0]) report("pos_x", word[47:0], w[47:0]);
      if (word[95:48] !== w[95:48]) report("pos_y", word[95:48], w[95:48]);
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  position_scoreboard sb = new();
  longint cycle_count = 0;
  bit quiet_mode = 1'b0;
  int hold_off = 0;

  optical_flow_position_integrator dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_position(m_axis_tdata);
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= quiet_mode || ($urandom_range(99) >= 23);
    end
  end

  task send_sample(logic [1:0] act, sample_t s);
    while (!quiet_mode && $urandom_range(99) < 23) @(posedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= s;
    s_axis_tuser <= act;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_sample(act, s);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [23:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_DIST_SCALE) sb.dist_scale = val;
    else if (idx == REG_PERIOD) sb.period = val[9:0];
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task wait_idle();
    while (sb.pending_pos.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  function sample_t rand_sample();
    sample_t s;
    s = 80'({$urandom, $urandom, $urandom});
    // keep heights small mostly so saturation is not constant
    if ($urandom_range(3) != 0) s.height_mm = 16'($urandom_range(3000));
    return s;
  endfunction

  function logic [1:0] rand_action();
    int r;
    r = $urandom_range(99);
    if (r < 40) return ACT_PLAIN;
    if (r < 92) return ACT_GYRO;
    if (r < 97) return ACT_CLEAR;
    return ACT_UNUSED;
  endfunction

  initial begin
    sample_t s;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, all actions, headings around the quadrant folds
    s = '{16'h0, 16'h0, 16'h0, 16'd1000, 8'sd10, -8'sd10};
    send_sample(ACT_PLAIN, s);
    s = '{16'h4000, 16'h7FFF, 16'h8000, 16'hFFFF, 8'h7F, 8'h80};
    send_sample(ACT_GYRO, s);
    s = '{16'h8000, 16'h8000, 16'h7FFF, 16'hFFFF, 8'h80, 8'h7F};
    send_sample(ACT_GYRO, s);
    s = '{16'hC000, 16'h1234, 16'hF00D, 16'd500, 8'd3, 8'hF0};
    send_sample(ACT_GYRO, s);
    s = '{16'h3FFF, 16'h0, 16'h0, 16'd500, 8'd3, 8'd5};
    send_sample(ACT_GYRO, s);
    send_sample(ACT_UNUSED, s);
    send_sample(ACT_CLEAR, s);
    send_sample(ACT_PLAIN, '{16'h0, 16'h0, 16'h0, 16'h0, 8'h80, 8'h7F});
    wait_idle();
    write_reg(REG_DIST_SCALE, 24'hFFFFFF);
    write_reg(REG_PERIOD, 24'd1000);
    write_reg(REG_UNUSED, 24'hABCDEF);
    // drive large moves in both directions
    for (int i = 0; i < 6; i++)
      send_sample(ACT_PLAIN, '{16'h0, 16'h0, 16'h0, 16'hFFFF, 8'h7F, 8'h80});
    for (int i = 0; i < 6; i++)
      send_sample(ACT_PLAIN, '{16'h0, 16'h0, 16'h0, 16'hFFFF, 8'h80, 8'h7F});
    send_sample(ACT_CLEAR, s);
    wait_idle();
    write_reg(REG_PERIOD, 24'd0);
    send_sample(ACT_GYRO, '{16'h2000, 16'h7FFF, 16'h7FFF, 16'd800, 8'd1, 8'd1});
    wait_idle();
    write_reg(REG_PERIOD, 24'h3FF);
    write_reg(REG_DIST_SCALE, 24'd0);
    send_sample(ACT_GYRO, '{16'h6000, 16'h8000, 16'h7FFF, 16'd800, 8'd1, 8'd1});
    wait_idle();

    // long receiver hold-off while the sender keeps offering
    hold_off = 400;
    for (int i = 0; i < 6; i++) send_sample(ACT_PLAIN, rand_sample());

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i % 250 == 0) begin
        wait_idle();
        case ((i / 250) % 4)
          0: begin
            write_reg(REG_DIST_SCALE, DIST_SCALE_RST);
            write_reg(REG_PERIOD, 24'(PERIOD_RST));
          end
          1: begin
            write_reg(REG_DIST_SCALE, 24'($urandom));
            write_reg(REG_PERIOD, 24'($urandom_range(1000, 1)));
          end
          2: begin
            write_reg(REG_DIST_SCALE, 24'($urandom));
            write_reg(REG_PERIOD, 24'($urandom));
          end
          default: begin
            write_reg(REG_DIST_SCALE, 24'd1);
            write_reg(REG_PERIOD, 24'd1);
          end
        endcase
      end
      quiet_mode = (i >= 500 && i < 650);
      send_sample(rand_action(), rand_sample());
    end
    quiet_mode = 1'b0;
    wait_idle();
    if (sb.errors == 0 && sb.pending_pos.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
